FILE: rtl/stc_pkg.sv
`default_nettype none
package stc_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int IDX_W            = 6;
  localparam int CNT_W            = 7;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/stc_touch.sv
`default_nettype none
// Touch test for one segment pair: thirteen exact sign evaluations issued
// one per cycle through a 3-stage pipe (operand select, multiply, add/sign).
module stc_touch #(
  parameter int CoordBits = stc_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic [4*CoordBits-1:0] seg_a,
  input  wire logic [4*CoordBits-1:0] seg_b,
  output logic                        done,
  output logic                        touch
);
  import stc_pkg::*;

  localparam int CB = CoordBits;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  localparam logic [3:0] OP_PAR  = 4'd0;
  localparam logic [3:0] OP_C_X  = 4'd1;
  localparam logic [3:0] OP_C_D  = 4'd2;
  localparam logic [3:0] OP_D_X  = 4'd3;
  localparam logic [3:0] OP_D_D  = 4'd4;
  localparam logic [3:0] OP_A_X  = 4'd5;
  localparam logic [3:0] OP_A_D  = 4'd6;
  localparam logic [3:0] OP_B_X  = 4'd7;
  localparam logic [3:0] OP_B_D  = 4'd8;
  localparam logic [3:0] OP_S1   = 4'd9;
  localparam logic [3:0] OP_S2   = 4'd10;
  localparam logic [3:0] OP_S3   = 4'd11;
  localparam logic [3:0] OP_S4   = 4'd12;
  localparam int         NOPS    = 13;

  function automatic logic signed [DW-1:0] dif(input logic [CB-1:0] x,
                                               input logic [CB-1:0] y);
    dif = $signed({x[CB-1], x}) - $signed({y[CB-1], y});
  endfunction

  logic [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  assign ax = seg_a[4*CB-1 -: CB];
  assign ay = seg_a[3*CB-1 -: CB];
  assign bx = seg_a[2*CB-1 -: CB];
  assign by = seg_a[CB-1 -: CB];
  assign cx = seg_b[4*CB-1 -: CB];
  assign cy = seg_b[3*CB-1 -: CB];
  assign dx = seg_b[2*CB-1 -: CB];
  assign dy = seg_b[CB-1 -: CB];

  logic              issue_r;
  logic [3:0]        op_r;
  logic signed [DW-1:0] px, py, qx, qy;
  logic              is_dot;

  always_comb begin
    px = '0; py = '0; qx = '0; qy = '0; is_dot = 1'b0;
    case (op_r)
      OP_PAR: begin
        px = dif(ax, bx); py = dif(ay, by); qx = dif(cx, dx); qy = dif(cy, dy);
      end
      OP_C_X, OP_C_D: begin
        px = dif(ax, cx); py = dif(ay, cy); qx = dif(bx, cx); qy = dif(by, cy);
        is_dot = (op_r == OP_C_D);
      end
      OP_D_X, OP_D_D: begin
        px = dif(ax, dx); py = dif(ay, dy); qx = dif(bx, dx); qy = dif(by, dy);
        is_dot = (op_r == OP_D_D);
      end
      OP_A_X, OP_A_D: begin
        px = dif(cx, ax); py = dif(cy, ay); qx = dif(dx, ax); qy = dif(dy, ay);
        is_dot = (op_r == OP_A_D);
      end
      OP_B_X, OP_B_D: begin
        px = dif(cx, bx); py = dif(cy, by); qx = dif(dx, bx); qy = dif(dy, by);
        is_dot = (op_r == OP_B_D);
      end
      OP_S1: begin
        px = dif(dx, cx); py = dif(dy, cy); qx = dif(ax, cx); qy = dif(ay, cy);
      end
      OP_S2: begin
        px = dif(dx, cx); py = dif(dy, cy); qx = dif(bx, cx); qy = dif(by, cy);
      end
      OP_S3: begin
        px = dif(bx, ax); py = dif(by, ay); qx = dif(cx, ax); qy = dif(cy, ay);
      end
      OP_S4: begin
        px = dif(bx, ax); py = dif(by, ay); qx = dif(dx, ax); qy = dif(dy, ay);
      end
      default: begin
        px = '0;
      end
    endcase
  end

  // stage A: operands
  logic                 vld_a_r, dot_a_r;
  logic [3:0]           op_a_r;
  logic signed [DW-1:0] pax_r, pay_r, qax_r, qay_r;
  // stage B: products
  logic                 vld_b_r, dot_b_r;
  logic [3:0]           op_b_r;
  logic signed [PW-1:0] m1_r, m2_r;
  logic signed [SW-1:0] sum;
  logic [NOPS-1:0]      neg_r, zero_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      op_r    <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (go) begin
        issue_r <= 1'b1;
        op_r    <= '0;
      end else if (issue_r) begin
        if (op_r == OP_S4) issue_r <= 1'b0;
        op_r <= op_r + 4'd1;
      end
      vld_a_r <= issue_r;
      vld_b_r <= vld_a_r;
      done_r  <= vld_b_r && (op_b_r == OP_S4);
    end
  end

  always_ff @(posedge clk) begin
    pax_r  <= px;
    pay_r  <= py;
    qax_r  <= qx;
    qay_r  <= qy;
    dot_a_r <= is_dot;
    op_a_r <= op_r;
    m1_r   <= dot_a_r ? pax_r * qax_r : pax_r * qay_r;
    m2_r   <= dot_a_r ? pay_r * qay_r : pay_r * qax_r;
    dot_b_r <= dot_a_r;
    op_b_r <= op_a_r;
    if (vld_b_r) begin
      neg_r[op_b_r]  <= sum[SW-1];
      zero_r[op_b_r] <= (sum == '0);
    end
  end

  assign sum = dot_b_r ? (SW'(m1_r) + SW'(m2_r)) : (SW'(m1_r) - SW'(m2_r));

  logic on_c, on_d, on_a, on_b, cross_ok1, cross_ok2;
  assign on_c = zero_r[OP_C_X] && (neg_r[OP_C_D] || zero_r[OP_C_D]);
  assign on_d = zero_r[OP_D_X] && (neg_r[OP_D_D] || zero_r[OP_D_D]);
  assign on_a = zero_r[OP_A_X] && (neg_r[OP_A_D] || zero_r[OP_A_D]);
  assign on_b = zero_r[OP_B_X] && (neg_r[OP_B_D] || zero_r[OP_B_D]);
  assign cross_ok1 = zero_r[OP_S1] || zero_r[OP_S2] || (neg_r[OP_S1] != neg_r[OP_S2]);
  assign cross_ok2 = zero_r[OP_S3] || zero_r[OP_S4] || (neg_r[OP_S3] != neg_r[OP_S4]);

  assign done  = done_r;
  assign touch = zero_r[OP_PAR] ? (on_c || on_d || on_a || on_b)
                                : (cross_ok1 && cross_ok2);

endmodule
`default_nettype wire

FILE: rtl/segment_touch_connectivity_unit.sv
`default_nettype none
// Load and ignored items: accepted with no result, busy stays low.
// Query: result strobe in the cycle after accept, busy for that one cycle.
// Build (n = effective count): each row segment is read once; per ordered pair of
// distinct segments the other one is read and 13 sign ops run through the 3-stage
// touch pipe; closure then updates every row per pivot. Results cannot be stalled.
// Synchronous active-low reset: control idle, count = 1, reach matrix reads empty.
module segment_touch_connectivity_unit #(
  parameter int MaxSegments = stc_pkg::MAX_SEGMENTS_DEF,
  parameter int CoordBits   = stc_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_mode,
  input  wire logic [stc_pkg::IDX_W-1:0] in_segment_index,
  input  wire logic [CoordBits-1:0]    in_start_x,
  input  wire logic [CoordBits-1:0]    in_start_y,
  input  wire logic [CoordBits-1:0]    in_end_x,
  input  wire logic [CoordBits-1:0]    in_end_y,
  input  wire logic [stc_pkg::IDX_W-1:0] in_first_index,
  input  wire logic [stc_pkg::IDX_W-1:0] in_second_index,
  output logic                         out_strobe,
  output logic                         out_connected,
  output logic                         out_index_error,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [stc_pkg::CNT_W-1:0] cfg_segment_count
);
  import stc_pkg::*;

  localparam int AW  = $clog2(MaxSegments);      // row / slot address
  localparam int NW  = $clog2(MaxSegments + 1);  // counts 0..MaxSegments
  localparam int XW  = (NW > IDX_W) ? NW : IDX_W; // index compare width
  localparam int CMW = (NW > CNT_W) ? NW : CNT_W; // count saturation width
  localparam int SGW = 4 * CoordBits;

  typedef enum logic [3:0] {
    S_IDLE, S_QUERY,
    S_ROW_RD, S_ROW_LAT, S_COL_RD, S_COL_LAT, S_TOUCH, S_ROW_WR,
    S_K_RD, S_K_LAT, S_I_RD, S_I_WR
  } state_t;

  state_t state_r;

  // configuration
  logic [CNT_W-1:0] count_r;
  assign cfg_ready = 1'b1;

  // effective count, saturated at the number of slots
  logic [CMW-1:0] cnt_w;
  logic [NW-1:0]  n_eff;
  assign cnt_w = CMW'(count_r);
  assign n_eff = (cnt_w > CMW'(MaxSegments)) ? NW'(MaxSegments) : cnt_w[NW-1:0];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // ---------------------------------------------------------------
  // Coordinate store: one word per slot, {sx, sy, ex, ey}
  // ---------------------------------------------------------------
  logic [SGW-1:0] coord_mem [MaxSegments];
  logic [SGW-1:0] coord_q_r;
  logic [AW-1:0]  coord_raddr;
  logic [XW-1:0]  load_slot;
  logic           load_we;

  assign load_slot = XW'(in_segment_index);
  assign load_we   = accept && (in_mode == MODE_LOAD) && (load_slot < XW'(MaxSegments));

  always_ff @(posedge clk) begin
    if (load_we) begin
      coord_mem[load_slot[AW-1:0]] <= {in_start_x, in_start_y, in_end_x, in_end_y};
    end
    coord_q_r <= coord_mem[coord_raddr];
  end

  // ---------------------------------------------------------------
  // Reach matrix: one row of MaxSegments bits per segment
  // ---------------------------------------------------------------
  logic [MaxSegments-1:0] reach_mem [MaxSegments];
  logic [MaxSegments-1:0] reach_q_r;
  logic [AW-1:0]          reach_raddr;
  logic [AW-1:0]          reach_waddr;
  logic [MaxSegments-1:0] reach_wdata;
  logic                   reach_we;

  always_ff @(posedge clk) begin
    if (reach_we) begin
      reach_mem[reach_waddr] <= reach_wdata;
    end
    reach_q_r <= reach_mem[reach_raddr];
  end

  // build counters and working registers
  logic [NW-1:0]          n_r;      // count in use by the running build
  logic [NW-1:0]          built_r;  // rows valid from the last build
  logic [NW-1:0]          i_r, j_r, k_r;
  logic [SGW-1:0]         seg_i_r, seg_j_r;
  logic [MaxSegments-1:0] acc_r;    // row being assembled
  logic [MaxSegments-1:0] rowk_r;   // pivot row of the closure

  // query registers
  logic          q_err_r, q_ok_r;
  logic [AW-1:0] q_bit_r;

  logic [XW-1:0] qa, qb;
  assign qa = XW'(in_first_index);
  assign qb = XW'(in_second_index);

  logic t_go, t_done, t_touch;

  stc_touch #(.CoordBits(CoordBits)) u_touch (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (t_go),
    .seg_a (seg_i_r),
    .seg_b (seg_j_r),
    .done  (t_done),
    .touch (t_touch)
  );

  assign t_go = (state_r == S_COL_LAT);

  // memory address and write muxing
  always_comb begin
    coord_raddr = i_r[AW-1:0];
    if (state_r == S_COL_RD) coord_raddr = j_r[AW-1:0];

    reach_raddr = AW'(in_first_index);
    if (state_r == S_K_RD) reach_raddr = k_r[AW-1:0];
    if (state_r == S_I_RD) reach_raddr = i_r[AW-1:0];

    reach_we    = (state_r == S_ROW_WR) || (state_r == S_I_WR);
    reach_waddr = i_r[AW-1:0];
    reach_wdata = acc_r;
    if (state_r == S_I_WR) begin
      reach_wdata = reach_q_r[k_r[AW-1:0]] ? (reach_q_r | rowk_r) : reach_q_r;
    end
  end

  // query result: valid in the cycle after accept, while out_strobe is high
  assign out_strobe      = (state_r == S_QUERY);
  assign out_index_error = q_err_r;
  assign out_connected   = !q_err_r && q_ok_r && reach_q_r[q_bit_r];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CNT_W'(1);
      built_r <= '0;
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) count_r <= cfg_segment_count;
      case (state_r)
        S_IDLE: begin
          if (accept && in_mode == MODE_QUERY) begin
            state_r <= S_QUERY;
          end else if (accept && in_mode == MODE_BUILD) begin
            n_r     <= n_eff;
            built_r <= n_eff;
            i_r     <= '0;
            if (n_eff != '0) state_r <= S_ROW_RD;
          end
        end
        S_QUERY:   state_r <= S_IDLE;
        S_ROW_RD:  state_r <= S_ROW_LAT;
        S_ROW_LAT: begin
          j_r     <= '0;
          state_r <= S_COL_RD;
        end
        S_COL_RD: begin
          if (j_r == n_r) begin
            state_r <= S_ROW_WR;
          end else if (j_r == i_r) begin
            j_r <= j_r + 1'b1;              // self link, set at row start
          end else begin
            state_r <= S_COL_LAT;
          end
        end
        S_COL_LAT: state_r <= S_TOUCH;
        S_TOUCH: begin
          if (t_done) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_COL_RD;
          end
        end
        S_ROW_WR: begin
          if (i_r + 1'b1 == n_r) begin
            k_r     <= '0;
            state_r <= S_K_RD;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ROW_RD;
          end
        end
        S_K_RD:  state_r <= S_K_LAT;
        S_K_LAT: begin
          i_r     <= '0;
          state_r <= S_I_RD;
        end
        S_I_RD:  state_r <= S_I_WR;
        S_I_WR: begin
          if (i_r + 1'b1 == n_r) begin
            if (k_r + 1'b1 == n_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_K_RD;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_I_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && in_mode == MODE_QUERY) begin
      q_err_r <= (qa >= XW'(n_eff)) || (qb >= XW'(n_eff));
      q_ok_r  <= (qa < XW'(built_r)) && (qb < XW'(built_r));
      q_bit_r <= AW'(in_second_index);
    end
    if (state_r == S_ROW_LAT) begin
      seg_i_r <= coord_q_r;
      acc_r   <= MaxSegments'(1) << i_r[AW-1:0];
    end
    if (state_r == S_COL_LAT) seg_j_r <= coord_q_r;
    if (state_r == S_TOUCH && t_done) acc_r[j_r[AW-1:0]] <= t_touch;
    if (state_r == S_K_LAT) rowk_r <= reach_q_r;
  end

endmodule
`default_nettype wire
